// ===== hdl/nonuniform_dft_field_map_engine_assert.svh =====
// assertion macros for the non-uniform dft engine checker
`ifndef NONUNIFORM_DFT_FIELD_MAP_ENGINE_ASSERT_SVH
`define NONUNIFORM_DFT_FIELD_MAP_ENGINE_ASSERT_SVH

// implication checked in the same cycle
`define NUDFT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication checked in the next cycle
`define NUDFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/nudft_pkg.sv =====
// shared types, constants and tables of the non-uniform dft engine
`default_nettype none
package nudft_pkg;

   localparam int MAX_ENTRIES_DEF = 4096;
   localparam int ANGLE_BITS_DEF  = 16;
   localparam int CORDIC_STEPS    = 24;
   localparam int TRIG_W          = 19;
   localparam int TERM_W          = 35;
   localparam int OUT_W           = 48;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_LOAD  = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   localparam logic [0:0] CSR_DIRECTION = 1'd0;
   localparam logic [0:0] CSR_Z_OFFSET  = 1'd1;

   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [21:0] TRIG_ONE  = 22'sd131072;

   typedef struct packed {
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic signed [31:0] re;
      logic signed [31:0] im;
   } entry_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cos;
      logic signed [TRIG_W-1:0] sin;
   } trig_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FETCH, ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_PH_END,
      ST_TRIG_GO, ST_TRIG_WAIT, ST_TERM0, ST_TERM1, ST_TERM2, ST_TERM3,
      ST_TERM4, ST_ACCUM, ST_FINISH
   } state_type;

   function automatic logic signed [31:0] atan_turns(input logic [4:0] i);
      case (i)
         5'd0:  atan_turns = 32'sh20000000;
         5'd1:  atan_turns = 32'sh12E4051E;
         5'd2:  atan_turns = 32'sh09FB385B;
         5'd3:  atan_turns = 32'sh051111D4;
         5'd4:  atan_turns = 32'sh028B0D43;
         5'd5:  atan_turns = 32'sh0145D7E1;
         5'd6:  atan_turns = 32'sh00A2F61E;
         5'd7:  atan_turns = 32'sh00517C55;
         5'd8:  atan_turns = 32'sh0028BE53;
         5'd9:  atan_turns = 32'sh00145F2F;
         5'd10: atan_turns = 32'sh000A2F98;
         5'd11: atan_turns = 32'sh000517CC;
         5'd12: atan_turns = 32'sh00028BE6;
         5'd13: atan_turns = 32'sh000145F3;
         5'd14: atan_turns = 32'sh0000A2FA;
         5'd15: atan_turns = 32'sh0000517D;
         5'd16: atan_turns = 32'sh000028BE;
         5'd17: atan_turns = 32'sh0000145F;
         5'd18: atan_turns = 32'sh00000A30;
         5'd19: atan_turns = 32'sh00000518;
         5'd20: atan_turns = 32'sh0000028C;
         5'd21: atan_turns = 32'sh00000146;
         5'd22: atan_turns = 32'sh000000A3;
         5'd23: atan_turns = 32'sh00000051;
         default: atan_turns = 32'sh00000000;
      endcase
   endfunction

endpackage
`default_nettype wire

// ===== hdl/nudft_store.sv =====
// entry store memory with registered read
`default_nettype none
module nudft_store #(
   parameter int MAX_ENTRIES = nudft_pkg::MAX_ENTRIES_DEF,
   parameter int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_W-1:0]    wr_addr,
   input  nudft_pkg::entry_type      wr_data,
   input  wire logic [ADDR_W-1:0]    rd_addr,
   output nudft_pkg::entry_type      rd_data
);

   nudft_pkg::entry_type mem [MAX_ENTRIES];
   nudft_pkg::entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule
`default_nettype wire

// ===== hdl/nudft_cordic.sv =====
// iterative cordic unit giving q1.17 cosine and sine of an angle
`default_nettype none
module nudft_cordic #(
   parameter int ANGLE_BITS = nudft_pkg::ANGLE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [ANGLE_BITS-1:0] angle,
   output logic                       done,
   output nudft_pkg::trig_type        result
);

   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [31:0] z_ff, z_in;
   logic [4:0]         step_ff, step_in;
   logic [1:0]         quad_ff, quad_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic [31:0]        sh;
   logic signed [33:0] dx, dy;
   logic signed [nudft_pkg::TRIG_W-1:0] cx, cy;

   function automatic logic signed [nudft_pkg::TRIG_W-1:0] clamp_trig(
      input logic signed [33:0] v);
      logic signed [34:0] t;
      logic signed [21:0] r;
      t = 35'(v) + 35'sd4096;
      r = 22'(t >>> 13);
      if (r > nudft_pkg::TRIG_ONE) begin
         r = nudft_pkg::TRIG_ONE;
      end else if (r < -nudft_pkg::TRIG_ONE) begin
         r = -nudft_pkg::TRIG_ONE;
      end
      clamp_trig = r[nudft_pkg::TRIG_W-1:0];
   endfunction

   assign sh = {angle, {(32 - ANGLE_BITS){1'b0}}} + 32'h2000_0000;
   assign dx = y_ff >>> step_ff;
   assign dy = x_ff >>> step_ff;

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      step_in = step_ff;
      quad_in = quad_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in = nudft_pkg::CORDIC_X0;
         y_in = '0;
         z_in = $signed({2'b00, sh[29:0]}) - 32'sh2000_0000;
         quad_in = sh[31:30];
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - nudft_pkg::atan_turns(step_ff);
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + nudft_pkg::atan_turns(step_ff);
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(nudft_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      step_ff <= step_in;
      quad_ff <= quad_in;
   end

   assign cx = clamp_trig(x_ff);
   assign cy = clamp_trig(y_ff);

   always_comb begin
      case (quad_ff)
         2'd0: begin
            result.cos = cx;
            result.sin = cy;
         end
         2'd1: begin
            result.cos = -cy;
            result.sin = cx;
         end
         2'd2: begin
            result.cos = -cx;
            result.sin = -cy;
         end
         default: begin
            result.cos = cy;
            result.sin = -cx;
         end
      endcase
   end

   assign done = done_ff;

endmodule
`default_nettype wire

// ===== hdl/nonuniform_dft_field_map_engine.sv =====
// top level: entry store, query sequencer, shared multiplier and accumulators
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | action, entry fields, query fields
//   rsp     | out       | rsp_valid/rsp_ready  | sum_re, sum_im, saturated
//   csr     | in        | csr_wr_en            | csr_index, csr_wdata
//
// clear and load complete when accepted; a query passes every loaded entry through
// the shared 32x32 multiplier (7 uses per entry) and the 24-step cordic.
// synchronous reset empties the store (count only) and clears all control state.
// a finished result waits in the output register; a new request is taken meanwhile,
// and a later query holds in its last step until the waiting result is taken.
`default_nettype none
module nonuniform_dft_field_map_engine #(
   parameter int MAX_ENTRIES = nudft_pkg::MAX_ENTRIES_DEF,
   parameter int ANGLE_BITS  = nudft_pkg::ANGLE_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_action,
   input  wire logic signed [31:0]  req_entry_a,
   input  wire logic signed [31:0]  req_entry_b,
   input  wire logic signed [31:0]  req_entry_c,
   input  wire logic signed [31:0]  req_entry_re,
   input  wire logic signed [31:0]  req_entry_im,
   input  wire logic signed [31:0]  req_query_a,
   input  wire logic signed [31:0]  req_query_b,
   input  wire logic signed [31:0]  req_query_c,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [47:0]       rsp_sum_re,
   output logic signed [47:0]       rsp_sum_im,
   output logic                     rsp_saturated,
   input  wire logic                csr_wr_en,
   input  wire logic [0:0]          csr_index,
   input  wire logic [31:0]         csr_wdata
);

   localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int SUM_W  = nudft_pkg::TERM_W + CNT_W;
   localparam int ACC_W  = (SUM_W > nudft_pkg::OUT_W + 1) ? SUM_W : nudft_pkg::OUT_W + 1;
   localparam int OW     = nudft_pkg::OUT_W;

   nudft_pkg::state_type state_ff, state_in;
   nudft_pkg::entry_type rd_data, wr_data;
   nudft_pkg::trig_type  trig;

   logic               direction_ff;
   logic [31:0]        z_offset_ff;
   logic [CNT_W-1:0]   count_ff, idx_ff;
   logic signed [31:0] qa_ff, qb_ff, qc_ff;
   logic [31:0]        phase_ff;
   logic signed [63:0] mul_ff;
   logic signed [31:0] mul_x, mul_y;
   logic signed [51:0] tre_ff, tim_ff;
   logic signed [ACC_W-1:0] acc_re_ff, acc_im_ff;
   logic               rsp_valid_ff;
   logic signed [OW-1:0] sum_re_ff, sum_im_ff;
   logic               sat_ff;
   logic               accept, wr_en, trig_start, trig_done, last_entry;
   logic [31:0]        ph_round;
   logic [ANGLE_BITS-1:0] angle;
   logic               ovf_re, ovf_im;
   logic signed [OW-1:0] sat_re, sat_im;

   function automatic logic signed [ACC_W-1:0] round_term(input logic signed [51:0] v);
      logic signed [51:0] t;
      t = (v + 52'sd65536) >>> 17;
      round_term = ACC_W'($signed(t[nudft_pkg::TERM_W-1:0]));
   endfunction

   assign accept = req_valid && req_ready;
   assign wr_en  = accept && (req_action == nudft_pkg::ACT_LOAD)
                   && (count_ff < CNT_W'(MAX_ENTRIES));
   assign wr_data = '{a: req_entry_a, b: req_entry_b, c: req_entry_c,
                      re: req_entry_re, im: req_entry_im};
   assign last_entry = (idx_ff + CNT_W'(1)) == count_ff;

   nudft_store #(.MAX_ENTRIES(MAX_ENTRIES), .ADDR_W(ADDR_W)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign ph_round = phase_ff + (32'd1 << (31 - ANGLE_BITS));
   assign angle = ph_round[31 -: ANGLE_BITS];

   nudft_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (trig_start),
      .angle  (angle),
      .done   (trig_done),
      .result (trig)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nudft_pkg::ST_IDLE: begin
            if (accept && req_action == nudft_pkg::ACT_QUERY) begin
               state_in = (count_ff == '0) ? nudft_pkg::ST_FINISH : nudft_pkg::ST_FETCH;
            end
         end
         nudft_pkg::ST_FETCH:     state_in = nudft_pkg::ST_MUL_A;
         nudft_pkg::ST_MUL_A:     state_in = nudft_pkg::ST_MUL_B;
         nudft_pkg::ST_MUL_B:     state_in = nudft_pkg::ST_MUL_C;
         nudft_pkg::ST_MUL_C:     state_in = nudft_pkg::ST_PH_END;
         nudft_pkg::ST_PH_END:    state_in = nudft_pkg::ST_TRIG_GO;
         nudft_pkg::ST_TRIG_GO:   state_in = nudft_pkg::ST_TRIG_WAIT;
         nudft_pkg::ST_TRIG_WAIT: begin
            if (trig_done) begin
               state_in = nudft_pkg::ST_TERM0;
            end
         end
         nudft_pkg::ST_TERM0:     state_in = nudft_pkg::ST_TERM1;
         nudft_pkg::ST_TERM1:     state_in = nudft_pkg::ST_TERM2;
         nudft_pkg::ST_TERM2:     state_in = nudft_pkg::ST_TERM3;
         nudft_pkg::ST_TERM3:     state_in = nudft_pkg::ST_TERM4;
         nudft_pkg::ST_TERM4:     state_in = nudft_pkg::ST_ACCUM;
         nudft_pkg::ST_ACCUM: begin
            state_in = last_entry ? nudft_pkg::ST_FINISH : nudft_pkg::ST_FETCH;
         end
         nudft_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = nudft_pkg::ST_IDLE;
            end
         end
         default: state_in = nudft_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready  = (state_ff == nudft_pkg::ST_IDLE);
      trig_start = (state_ff == nudft_pkg::ST_TRIG_GO);
      mul_x = 32'(trig.cos);
      mul_y = rd_data.re;
      case (state_ff)
         nudft_pkg::ST_MUL_A: begin
            mul_x = rd_data.a;
            mul_y = qa_ff;
         end
         nudft_pkg::ST_MUL_B: begin
            mul_x = rd_data.b;
            mul_y = qb_ff;
         end
         nudft_pkg::ST_MUL_C: begin
            mul_x = rd_data.c;
            mul_y = qc_ff;
         end
         nudft_pkg::ST_TERM1: begin
            mul_x = 32'(trig.sin);
            mul_y = rd_data.im;
         end
         nudft_pkg::ST_TERM2: begin
            mul_x = 32'(trig.cos);
            mul_y = rd_data.im;
         end
         nudft_pkg::ST_TERM3: begin
            mul_x = 32'(trig.sin);
            mul_y = rd_data.re;
         end
         default: begin
            mul_x = 32'(trig.cos);
            mul_y = rd_data.re;
         end
      endcase
   end

   assign ovf_re = (|acc_re_ff[ACC_W-1:OW-1]) && !(&acc_re_ff[ACC_W-1:OW-1]);
   assign ovf_im = (|acc_im_ff[ACC_W-1:OW-1]) && !(&acc_im_ff[ACC_W-1:OW-1]);
   assign sat_re = !ovf_re ? acc_re_ff[OW-1:0]
                 : (acc_re_ff[ACC_W-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}});
   assign sat_im = !ovf_im ? acc_im_ff[OW-1:0]
                 : (acc_im_ff[ACC_W-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nudft_pkg::ST_IDLE;
         count_ff     <= '0;
         direction_ff <= 1'b0;
         z_offset_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               nudft_pkg::CSR_DIRECTION: direction_ff <= csr_wdata[0];
               nudft_pkg::CSR_Z_OFFSET:  z_offset_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (accept && req_action == nudft_pkg::ACT_CLEAR) begin
            count_ff <= '0;
         end else if (wr_en) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (state_ff == nudft_pkg::ST_FINISH && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      mul_ff <= mul_x * mul_y;
      case (state_ff)
         nudft_pkg::ST_IDLE: begin
            qa_ff <= req_query_a;
            qb_ff <= req_query_b;
            qc_ff <= req_query_c;
            idx_ff <= '0;
            acc_re_ff <= '0;
            acc_im_ff <= '0;
         end
         nudft_pkg::ST_MUL_A: phase_ff <= {z_offset_ff[15:0], 16'h0000};
         nudft_pkg::ST_MUL_B: phase_ff <= phase_ff + mul_ff[31:0];
         nudft_pkg::ST_MUL_C: phase_ff <= phase_ff + mul_ff[31:0];
         nudft_pkg::ST_PH_END: phase_ff <= phase_ff + mul_ff[31:0];
         nudft_pkg::ST_TERM1: tre_ff <= mul_ff[51:0];
         nudft_pkg::ST_TERM2: begin
            tre_ff <= direction_ff ? tre_ff - mul_ff[51:0] : tre_ff + mul_ff[51:0];
         end
         nudft_pkg::ST_TERM3: begin
            tim_ff <= mul_ff[51:0];
            acc_re_ff <= acc_re_ff + round_term(tre_ff);
         end
         nudft_pkg::ST_TERM4: begin
            tim_ff <= direction_ff ? tim_ff + mul_ff[51:0] : tim_ff - mul_ff[51:0];
         end
         nudft_pkg::ST_ACCUM: begin
            acc_im_ff <= acc_im_ff + round_term(tim_ff);
            idx_ff <= idx_ff + CNT_W'(1);
         end
         nudft_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               sum_re_ff <= sat_re;
               sum_im_ff <= sat_im;
               sat_ff <= ovf_re || ovf_im;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sum_re    = sum_re_ff;
   assign rsp_sum_im    = sum_im_ff;
   assign rsp_saturated = sat_ff;

endmodule
`default_nettype wire

// ===== hdl/nudft_checker.sv =====
// port-level checker for the non-uniform dft engine, bound to the top level
`default_nettype none
`include "nonuniform_dft_field_map_engine_assert.svh"
module nudft_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic [1:0]         req_action,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [47:0] rsp_sum_re,
   input wire logic signed [47:0] rsp_sum_im,
   input wire logic               rsp_saturated
);

   logic sat_ok;
   assign sat_ok = (rsp_sum_re == 48'sh7FFF_FFFF_FFFF) || (rsp_sum_re == 48'sh8000_0000_0000)
                || (rsp_sum_im == 48'sh7FFF_FFFF_FFFF) || (rsp_sum_im == 48'sh8000_0000_0000);

   `NUDFT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sum_re) && $stable(rsp_sum_im))
   `NUDFT_ASSERT_NEXT(a_query_busy, clock, reset, req_valid && req_ready && req_action == nudft_pkg::ACT_QUERY, !req_ready)
   `NUDFT_ASSERT_NEXT(a_no_rsp_for_load, clock, reset, req_valid && req_ready && req_action != nudft_pkg::ACT_QUERY && !rsp_valid, !rsp_valid)
   `NUDFT_ASSERT_SAME(a_sat_at_limit, clock, reset, rsp_valid && rsp_saturated, sat_ok)

endmodule

bind nonuniform_dft_field_map_engine nudft_checker u_nudft_checker (.*);
`default_nettype wire

// ===== sim/nonuniform_dft_field_map_engine_tb.sv =====
// self-checking testbench for the non-uniform dft field map engine
`timescale 1ns / 100ps
`default_nettype none
module nonuniform_dft_field_map_engine_tb;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam longint SUM_MAX = 64'sh00007FFFFFFFFFFF;
   localparam longint SUM_MIN = -SUM_MAX - 1;
   localparam int STORE_DEPTH = nudft_pkg::MAX_ENTRIES_DEF;

   typedef struct {
      logic signed [47:0] re;
      logic signed [47:0] im;
      logic               sat;
   } dft_sum_type;

   class dft_scoreboard;
      nudft_pkg::entry_type entries[$];
      bit          inverse;
      logic [31:0] z_turns;
      dft_sum_type sums_due[$];
      int          errors;
      longint      atan_tab[24] = '{
         64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
         64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
         64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
         64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
         64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

      function void write_csr(logic [0:0] idx, logic [31:0] data);
         if (idx == nudft_pkg::CSR_DIRECTION) inverse = data[0];
         else z_turns = data;
      endfunction

      function logic [31:0] frac_turns(logic signed [31:0] p, logic signed [31:0] q);
         longint prod;
         prod = longint'(p) * longint'(q);
         return prod[31:0];
      endfunction

      function longint trig_round(longint v);
         longint r;
         r = (v + 4096) >>> 13;
         if (r > 131072) r = 131072;
         if (r < -131072) r = -131072;
         return r;
      endfunction

      function void sincos(logic [15:0] ang, output longint c, output longint s);
         logic [31:0] sh;
         longint x, y, z, dx, dy;
         sh = {ang, 16'h0} + 32'h20000000;
         z = longint'({34'b0, sh[29:0]}) - 64'sh20000000;
         x = 652032874;
         y = 0;
         for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_tab[i];
            end else begin
               x += dx; y -= dy; z += atan_tab[i];
            end
         end
         x = trig_round(x);
         y = trig_round(y);
         case (sh[31:30])
            2'd0: begin c = x; s = y; end
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
         endcase
      endfunction

      function void note(logic [1:0] act, nudft_pkg::entry_type e, logic signed [31:0] qa,
                         logic signed [31:0] qb, logic signed [31:0] qc);
         logic [31:0] ph;
         logic [15:0] ang;
         longint c, s, er, ei, acc_re, acc_im;
         dft_sum_type r;
         if (act == nudft_pkg::ACT_CLEAR) entries.delete();
         else if (act == nudft_pkg::ACT_LOAD) begin
            if (entries.size() < STORE_DEPTH) entries.push_back(e);
         end else if (act == nudft_pkg::ACT_QUERY) begin
            acc_re = 0;
            acc_im = 0;
            foreach (entries[k]) begin
               ph = frac_turns(entries[k].a, qa) + frac_turns(entries[k].b, qb)
                  + frac_turns(entries[k].c, qc) + {z_turns[15:0], 16'h0};
               ang = (ph + 32'h8000) >> 16;
               sincos(ang, c, s);
               er = entries[k].re;
               ei = entries[k].im;
               if (!inverse) begin
                  acc_re += (c * er + s * ei + 65536) >>> 17;
                  acc_im += (c * ei - s * er + 65536) >>> 17;
               end else begin
                  acc_re += (c * er - s * ei + 65536) >>> 17;
                  acc_im += (c * ei + s * er + 65536) >>> 17;
               end
            end
            r.sat = 0;
            if (acc_re > SUM_MAX) begin acc_re = SUM_MAX; r.sat = 1; end
            if (acc_re < SUM_MIN) begin acc_re = SUM_MIN; r.sat = 1; end
            if (acc_im > SUM_MAX) begin acc_im = SUM_MAX; r.sat = 1; end
            if (acc_im < SUM_MIN) begin acc_im = SUM_MIN; r.sat = 1; end
            r.re = acc_re[47:0];
            r.im = acc_im[47:0];
            sums_due.push_back(r);
         end
      endfunction

      function void check(logic signed [47:0] re, logic signed [47:0] im, logic sat);
         dft_sum_type x;
         if (sums_due.size() == 0) begin
            $display("%0t: unexpected response re %0d im %0d sat %0d", $time, re, im, sat);
            errors++;
            return;
         end
         x = sums_due.pop_front();
         if (re !== x.re) begin
            $display("%0t: sum_re expected %0d actual %0d", $time, x.re, re);
            errors++;
         end
         if (im !== x.im) begin
            $display("%0t: sum_im expected %0d actual %0d", $time, x.im, im);
            errors++;
         end
         if (sat !== x.sat) begin
            $display("%0t: saturated expected %0d actual %0d", $time, x.sat, sat);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready;
   logic [1:0] req_action;
   logic signed [31:0] req_entry_a, req_entry_b, req_entry_c, req_entry_re, req_entry_im;
   logic signed [31:0] req_query_a, req_query_b, req_query_c;
   logic rsp_valid, rsp_ready, rsp_saturated;
   logic signed [47:0] rsp_sum_re, rsp_sum_im;
   logic csr_wr_en;
   logic [0:0] csr_index;
   logic [31:0] csr_wdata;

   dft_scoreboard sb;
   bit quiet;
   int stall;

   nonuniform_dft_field_map_engine i_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // response side stalls
   initial begin
      rsp_ready = 0;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp_ready <= 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 12) - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check(rsp_sum_re, rsp_sum_im, rsp_saturated);
   end

   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(0, 1 << 19) - (1 << 18);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(logic [1:0] act, nudft_pkg::entry_type e, logic [31:0] qa,
                               logic [31:0] qb, logic [31:0] qc);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid    <= 1;
      req_action   <= act;
      req_entry_a  <= e.a;
      req_entry_b  <= e.b;
      req_entry_c  <= e.c;
      req_entry_re <= e.re;
      req_entry_im <= e.im;
      req_query_a  <= qa;
      req_query_b  <= qb;
      req_query_c  <= qc;
      do @(posedge clock); while (!req_ready);
      sb.note(act, e, qa, qb, qc);
   endtask

   task automatic random_request(logic [1:0] act);
      nudft_pkg::entry_type e;
      e.a = pick32(); e.b = pick32(); e.c = pick32();
      e.re = pick32(); e.im = pick32();
      send_request(act, e, pick32(), pick32(), pick32());
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (sb.sums_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 0;
      sb.write_csr(idx, data);
   endtask

   task automatic random_phase(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         if (sb.entries.size() >= 24) random_request(nudft_pkg::ACT_CLEAR);
         r = $urandom_range(0, 99);
         if (r < 5) random_request(nudft_pkg::ACT_CLEAR);
         else if (r < 55) random_request(nudft_pkg::ACT_LOAD);
         else if (r < 95) random_request(nudft_pkg::ACT_QUERY);
         else begin
            random_request(ACT_UNUSED);
            i--;
         end
      end
   endtask

   initial begin
      nudft_pkg::entry_type e;
      sb = new();
      quiet = 0;
      reset = 1;
      req_valid = 0; req_action = nudft_pkg::ACT_CLEAR;
      req_entry_a = 0; req_entry_b = 0; req_entry_c = 0; req_entry_re = 0; req_entry_im = 0;
      req_query_a = 0; req_query_b = 0; req_query_c = 0;
      csr_wr_en = 0; csr_index = nudft_pkg::CSR_DIRECTION; csr_wdata = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: empty store, extremes, unused code
      write_csr(nudft_pkg::CSR_DIRECTION, 0);
      write_csr(nudft_pkg::CSR_Z_OFFSET, 0);
      random_request(nudft_pkg::ACT_QUERY);
      random_request(ACT_UNUSED);
      e = '{a: 32'h7FFFFFFF, b: 32'h80000000, c: 32'h7FFFFFFF,
            re: 32'h7FFFFFFF, im: 32'h80000000};
      send_request(nudft_pkg::ACT_LOAD, e, 0, 0, 0);
      e = '{a: 32'h80000000, b: 32'h7FFFFFFF, c: 32'h80000000,
            re: 32'h80000000, im: 32'h7FFFFFFF};
      send_request(nudft_pkg::ACT_LOAD, e, 0, 0, 0);
      e = '{a: 32'h00010000, b: 32'h00008000, c: 0, re: 32'h00010000, im: 0};
      send_request(nudft_pkg::ACT_LOAD, e, 0, 0, 0);
      send_request(nudft_pkg::ACT_QUERY, e, 0, 0, 0);
      send_request(nudft_pkg::ACT_QUERY, e, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      send_request(nudft_pkg::ACT_QUERY, e, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      send_request(nudft_pkg::ACT_QUERY, e, 32'h00004000, 32'h00002000, 32'h00001000);
      drain();
      write_csr(nudft_pkg::CSR_DIRECTION, 1);
      write_csr(nudft_pkg::CSR_Z_OFFSET, 32'h7FFFFFFF);
      send_request(nudft_pkg::ACT_QUERY, e, 32'h00004000, 32'h00002000, 32'h00001000);
      send_request(nudft_pkg::ACT_QUERY, e, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      random_request(nudft_pkg::ACT_CLEAR);
      random_request(nudft_pkg::ACT_QUERY);
      drain();

      // random phases over several settings
      write_csr(nudft_pkg::CSR_DIRECTION, 0);
      write_csr(nudft_pkg::CSR_Z_OFFSET, 0);
      random_phase(32);
      drain();
      write_csr(nudft_pkg::CSR_DIRECTION, 1);
      write_csr(nudft_pkg::CSR_Z_OFFSET, 32'h80000000);
      random_phase(32);
      drain();
      write_csr(nudft_pkg::CSR_DIRECTION, 0);
      write_csr(nudft_pkg::CSR_Z_OFFSET, 32'h7FFFFFFF);
      random_phase(32);
      drain();
      write_csr(nudft_pkg::CSR_DIRECTION, $urandom_range(0, 1));
      write_csr(nudft_pkg::CSR_Z_OFFSET, $urandom);
      quiet = 1;
      random_phase(32);
      drain();

      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire
